// File: rtl/core/dmbm_pkg.sv
`default_nettype none

package dmbm_pkg;

    // Default bound on the candidate index
    localparam int DMBM_MAX_MODES = 256;

    // Field widths
    localparam int W_W     = 16;
    localparam int H_W     = 16;
    localparam int R_W     = 20;
    localparam int TR_W    = 21;
    localparam int HZ_W    = 11;
    localparam int IDX_OUT = 8;
    localparam int S_DATA_W = 56;
    localparam int M_DATA_W = 64;
    localparam int M_USER_W = 2;

    // Register indexes on the configuration port
    typedef enum logic [1:0] {
        CFG_TARGET_WIDTH   = 2'd0,
        CFG_TARGET_HEIGHT  = 2'd1,
        CFG_TARGET_REFRESH = 2'd2,
        CFG_TARGET_ANY     = 2'd3
    } cfg_addr_t;

    // Width is the most significant part, so a plain compare gives the mode order
    typedef struct packed {
        logic [W_W-1:0] width;
        logic [H_W-1:0] height;
        logic [R_W-1:0] refresh;
    } mode_t;

    typedef struct packed {
        logic exact_take;
        logic best_take;
    } eval_t;

    // floor(n / 1000) = floor(floor(n / 8) / 125); 268436 = ceil(2^25 / 125),
    // exact for every 18-bit dividend
    localparam logic [18:0] DIV125_RECIP = 19'd268436;

    function automatic logic [HZ_W-1:0] div1000(input logic [TR_W-1:0] n);
        logic [17:0] m;
        logic [36:0] prod;
        m    = n[TR_W-1:3];
        prod = m * DIV125_RECIP;
        return prod[35:25];
    endfunction

endpackage

`default_nettype wire

// File: rtl/core/display_mode_best_match_top.sv
// Channel | Dir | Beat contents
// s_      | in  | tdata: mode_width[15:0], mode_height[31:16], mode_refresh[51:32]; tlast: last_mode
// m_      | out | tdata: chosen_index[7:0], width[23:8], height[39:24], refresh[59:40];
//         |     | tuser: found[0], exact[1]
// cfg_    | in  | write: cfg_addr selects target_width/height/refresh/any, cfg_wdata
//
// One mode per cycle unless a last beat waits on an unaccepted result; m_tvalid rises
// when the last beat of a list passes from the input register to the result register.
// The input register feeds one compare stage (one reciprocal multiply for the
// rounded Hz plus the running best compare) that writes the result register.
// Reset is synchronous; it restores the targets and clears the running choice.
// The input side stalls only when a last beat meets a full, unaccepted result.

`default_nettype none

module display_mode_best_match_top #(
    parameter int MAX_MODES = dmbm_pkg::DMBM_MAX_MODES
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    // configuration
    input  logic                          cfg_wr_en,
    input  dmbm_pkg::cfg_addr_t           cfg_addr,
    input  logic [dmbm_pkg::TR_W-1:0]     cfg_wdata,
    // candidates
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [dmbm_pkg::S_DATA_W-1:0] s_tdata,  // mode_width, mode_height, mode_refresh
    input  logic                          s_tlast,
    // report
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [dmbm_pkg::M_DATA_W-1:0] m_tdata,  // chosen_index, width, height, refresh
    output logic [dmbm_pkg::M_USER_W-1:0] m_tuser   // found, exact
);
    import dmbm_pkg::*;

    localparam int              IDX_W    = $clog2(MAX_MODES);
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(MAX_MODES - 1);

    // Target registers
    logic [W_W-1:0]  tgt_width_reg;
    logic [H_W-1:0]  tgt_height_reg;
    logic [TR_W-1:0] tgt_refresh_reg;
    logic            tgt_any_reg;
    logic [HZ_W-1:0] tgt_hz_reg;
    logic            tgt_hz_ok_reg;

    logic signed [TR_W:0] cfg_sum;
    logic [HZ_W-1:0]      cfg_hz;
    logic                 cfg_hz_ok;

    // Target rounded Hz, truncated toward zero; only a zero quotient can
    // match when the rounded sum is negative
    always_comb begin
        cfg_sum = $signed({cfg_wdata[TR_W-1], cfg_wdata}) + (TR_W+1)'(500);
        if (!cfg_sum[TR_W]) begin
            cfg_hz    = div1000(cfg_sum[TR_W-1:0]);
            cfg_hz_ok = 1'b1;
        end else begin
            cfg_hz    = '0;
            cfg_hz_ok = (cfg_sum > -(TR_W+1)'(1000));
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tgt_width_reg   <= '0;
            tgt_height_reg  <= '0;
            tgt_refresh_reg <= '1;
            tgt_any_reg     <= 1'b0;
            tgt_hz_reg      <= '0;
            tgt_hz_ok_reg   <= 1'b1;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                CFG_TARGET_WIDTH:   tgt_width_reg  <= cfg_wdata[W_W-1:0];
                CFG_TARGET_HEIGHT:  tgt_height_reg <= cfg_wdata[H_W-1:0];
                CFG_TARGET_REFRESH: begin
                    tgt_refresh_reg <= cfg_wdata;
                    tgt_hz_reg      <= cfg_hz;
                    tgt_hz_ok_reg   <= cfg_hz_ok;
                end
                CFG_TARGET_ANY:     tgt_any_reg    <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    // Input register
    logic  in_valid_reg, in_valid_next;
    mode_t in_mode_reg;
    logic  in_last_reg;
    logic  m_valid_reg, m_valid_next;
    logic  advance;
    logic  accept;

    assign advance  = in_valid_reg && (!in_last_reg || !m_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign accept   = s_tvalid && s_tready;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (accept)
            in_valid_next = 1'b1;
        else if (advance)
            in_valid_next = 1'b0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            in_mode_reg.width   <= s_tdata[15:0];
            in_mode_reg.height  <= s_tdata[31:16];
            in_mode_reg.refresh <= s_tdata[51:32];
            in_last_reg         <= s_tlast;
        end
    end

    // Running choice
    logic             exact_valid_reg, exact_valid_next;
    logic [IDX_W-1:0] exact_index_reg, exact_index_next;
    mode_t            exact_mode_reg, exact_mode_next;
    logic             best_valid_reg, best_valid_next;
    logic [IDX_W-1:0] best_index_reg, best_index_next;
    mode_t            best_mode_reg, best_mode_next;
    logic [IDX_W-1:0] count_reg, count_next;
    eval_t            decision;

    dmbm_eval u_eval (
        .tgt_width   (tgt_width_reg),
        .tgt_height  (tgt_height_reg),
        .tgt_refresh (tgt_refresh_reg),
        .tgt_any     (tgt_any_reg),
        .tgt_hz      (tgt_hz_reg),
        .tgt_hz_ok   (tgt_hz_ok_reg),
        .mode        (in_mode_reg),
        .exact_valid (exact_valid_reg),
        .best_valid  (best_valid_reg),
        .best_mode   (best_mode_reg),
        .decision    (decision)
    );

    // Choice after this beat
    logic             exact_valid_upd, best_valid_upd;
    logic [IDX_W-1:0] exact_index_upd, best_index_upd;
    mode_t            exact_mode_upd, best_mode_upd;

    always_comb begin
        exact_valid_upd = exact_valid_reg | decision.exact_take;
        exact_index_upd = decision.exact_take ? count_reg : exact_index_reg;
        exact_mode_upd  = decision.exact_take ? in_mode_reg : exact_mode_reg;
        best_valid_upd  = best_valid_reg | decision.best_take;
        best_index_upd  = decision.best_take ? count_reg : best_index_reg;
        best_mode_upd   = decision.best_take ? in_mode_reg : best_mode_reg;
    end

    always_comb begin
        exact_valid_next = exact_valid_reg;
        exact_index_next = exact_index_reg;
        exact_mode_next  = exact_mode_reg;
        best_valid_next  = best_valid_reg;
        best_index_next  = best_index_reg;
        best_mode_next   = best_mode_reg;
        count_next       = count_reg;
        if (advance) begin
            exact_index_next = exact_index_upd;
            exact_mode_next  = exact_mode_upd;
            best_index_next  = best_index_upd;
            best_mode_next   = best_mode_upd;
            if (in_last_reg) begin
                // list done: start over
                exact_valid_next = 1'b0;
                best_valid_next  = 1'b0;
                count_next       = '0;
            end else begin
                exact_valid_next = exact_valid_upd;
                best_valid_next  = best_valid_upd;
                if (count_reg != IDX_LAST)
                    count_next = count_reg + IDX_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            exact_valid_reg <= 1'b0;
            best_valid_reg  <= 1'b0;
            count_reg       <= '0;
        end else begin
            exact_valid_reg <= exact_valid_next;
            best_valid_reg  <= best_valid_next;
            count_reg       <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        exact_index_reg <= exact_index_next;
        exact_mode_reg  <= exact_mode_next;
        best_index_reg  <= best_index_next;
        best_mode_reg   <= best_mode_next;
    end

    // Report selection: exact first, then best, else all zero
    logic                 rep_found;
    logic                 rep_exact;
    logic [IDX_W-1:0]     rep_index;
    mode_t                rep_mode;
    logic [IDX_W+IDX_OUT-1:0] rep_index_ext;
    logic [M_DATA_W-1:0]  m_data_reg, m_data_next;
    logic [M_USER_W-1:0]  m_user_reg, m_user_next;

    always_comb begin
        rep_found = exact_valid_upd || best_valid_upd;
        rep_exact = exact_valid_upd;
        if (exact_valid_upd) begin
            rep_index = exact_index_upd;
            rep_mode  = exact_mode_upd;
        end else if (best_valid_upd) begin
            rep_index = best_index_upd;
            rep_mode  = best_mode_upd;
        end else begin
            rep_index = '0;
            rep_mode  = '0;
        end
        rep_index_ext = {{IDX_OUT{1'b0}}, rep_index};
        m_data_next   = {4'b0, rep_mode.refresh, rep_mode.height, rep_mode.width,
                         rep_index_ext[IDX_OUT-1:0]};
        m_user_next   = {rep_exact, rep_found};
    end

    // Result register
    assign m_valid_next = (advance && in_last_reg) || (m_valid_reg && !m_tready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && in_last_reg) begin
            m_data_reg <= m_data_next;
            m_user_reg <= m_user_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;

endmodule

`default_nettype wire

// File: rtl/core/dmbm_eval.sv
`default_nettype none

module dmbm_eval (
    input  logic [dmbm_pkg::W_W-1:0]  tgt_width,
    input  logic [dmbm_pkg::H_W-1:0]  tgt_height,
    input  logic [dmbm_pkg::TR_W-1:0] tgt_refresh,
    input  logic                      tgt_any,
    input  logic [dmbm_pkg::HZ_W-1:0] tgt_hz,
    input  logic                      tgt_hz_ok,
    input  dmbm_pkg::mode_t           mode,
    input  logic                      exact_valid,
    input  logic                      best_valid,
    input  dmbm_pkg::mode_t           best_mode,
    output dmbm_pkg::eval_t           decision
);
    import dmbm_pkg::*;

    logic            res_eq;
    logic            is_exact;
    logic            refresh_any;
    logic [HZ_W-1:0] cand_hz;
    logic            hz_match;
    logic            satisfies;
    logic            greater;

    // Resolution and exact millihertz match; a negative target never matches
    assign res_eq   = (mode.width == tgt_width) && (mode.height == tgt_height);
    assign is_exact = res_eq && !tgt_refresh[TR_W-1] &&
                      (mode.refresh == tgt_refresh[R_W-1:0]);

    // Rounded Hz compare
    assign refresh_any = (tgt_refresh == {TR_W{1'b1}});
    assign cand_hz     = div1000({1'b0, mode.refresh} + TR_W'(500));
    assign hz_match    = tgt_hz_ok && (cand_hz == tgt_hz);
    assign satisfies   = tgt_any || (res_eq && (refresh_any || hz_match));

    // Width, then height, then refresh
    assign greater = (mode > best_mode);

    // First seen wins on ties
    assign decision.exact_take = is_exact && !exact_valid;
    assign decision.best_take  = satisfies && (!best_valid || greater);

endmodule

`default_nettype wire

// File: rtl/core/dmbm_checker.sv
`default_nettype none

module dmbm_checker (
    input wire logic                          aclk,
    input wire logic                          aresetn,
    input wire logic                          m_tvalid,
    input wire logic                          m_tready,
    input wire logic [dmbm_pkg::M_DATA_W-1:0] m_tdata,
    input wire logic [dmbm_pkg::M_USER_W-1:0] m_tuser
);
    import dmbm_pkg::*;

    // A report leaves the result register only when taken
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("report beat changed while stalled");

    // An exact report is always a found report
    a_exact_found: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[1] |-> m_tuser[0])
        else $error("exact set without found");

    // Nothing found reports all-zero fields
    a_empty_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser[0] |-> (m_tdata == '0) && !m_tuser[1])
        else $error("empty report carries data");

    // Reset drops any pending report
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("report valid after reset");

endmodule

bind display_mode_best_match_top dmbm_checker u_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

`default_nettype wire
